/* sv/nsf_pkg.sv */
`timescale 1ns / 1ps

package nsf_pkg;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Framing characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_A      = 8'h41;

  localparam logic [15:0] POS_MAX = 16'hFFFF;

  // One classified payload word as queued for the back end
  typedef struct packed {
    logic [7:0] data;
    logic       first;  // opens a sentence, '$' goes out ahead of it
    logic       last;   // closes a sentence, trailer follows
    logic [7:0] cs;     // checksum including this word
  } nsf_entry_t;

  // Upper-case hex digit of the low nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] d;
    if (v < 4'd10) begin
      d = CH_ZERO + {4'd0, v};
    end else begin
      d = CH_A + {4'd0, v} - 8'd10;
    end
    return d;
  endfunction

endpackage

/* sv/nsf_front.sv */
`timescale 1ns / 1ps

module nsf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_payload_byte,
  input  logic              in_last_byte,
  input  logic              q_full,
  output logic              push,
  output nsf_pkg::nsf_entry_t push_entry
);

  logic       in_sent_r;
  logic [7:0] cs_r;
  logic       excl;
  logic [7:0] cs_base;
  logic [7:0] cs_nxt;

  // Checksum skips the framing characters; a new sentence starts from zero
  assign excl    = (in_payload_byte == nsf_pkg::CH_DOLLAR) ||
                   (in_payload_byte == nsf_pkg::CH_STAR);
  assign cs_base = in_sent_r ? cs_r : 8'd0;
  assign cs_nxt  = cs_base ^ (excl ? 8'd0 : in_payload_byte);

  assign push = in_valid && !q_full;

  always_comb begin
    push_entry.data  = in_payload_byte;
    push_entry.first = !in_sent_r;
    push_entry.last  = in_last_byte;
    push_entry.cs    = cs_nxt;
  end

  // Sentence tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sent_r <= 1'b0;
      cs_r      <= 8'd0;
    end else if (push) begin
      in_sent_r <= !in_last_byte;
      cs_r      <= cs_nxt;
    end
  end

endmodule

/* sv/nsf_queue.sv */
`timescale 1ns / 1ps

module nsf_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  nsf_pkg::nsf_entry_t push_entry,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output nsf_pkg::nsf_entry_t head
);

  nsf_pkg::nsf_entry_t            mem_r [nsf_pkg::QDEPTH];
  logic [nsf_pkg::QAW-1:0]        wr_ptr_r;
  logic [nsf_pkg::QAW-1:0]        rd_ptr_r;
  logic [nsf_pkg::QCW-1:0]        cnt_r;

  assign full      = (cnt_r == nsf_pkg::QCW'(nsf_pkg::QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* sv/nsf_back.sv */
`timescale 1ns / 1ps

module nsf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  nsf_pkg::nsf_entry_t head,
  output logic                pop,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_max_length,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                out_within_buffer,
  output logic                out_end_of_sentence,
  output logic [15:0]         out_total_count
);

  typedef enum logic [6:0] {
    ST_START = 7'b0000001,
    ST_BODY  = 7'b0000010,
    ST_STAR  = 7'b0000100,
    ST_HI    = 7'b0001000,
    ST_LO    = 7'b0010000,
    ST_CR    = 7'b0100000,
    ST_LF    = 7'b1000000
  } bk_state_t;

  bk_state_t   st_r, st_nxt;
  logic [15:0] max_len_r;
  logic [15:0] pos_r;
  logic [15:0] emit_pos;
  logic [15:0] pos_inc;
  logic [7:0]  ch;
  logic        eos;
  logic        done;
  logic        load;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        within_r;
  logic        eos_r;
  logic [15:0] total_r;

  assign cfg_ready = 1'b1;

  // Output register takes a new word when empty or being drained
  assign load = head_valid && (!out_valid_r || !out_stall);
  assign pop  = load && done;

  // Emission sequencer: '$', body byte, then trailer
  always_comb begin
    st_nxt   = st_r;
    ch       = head.data;
    emit_pos = pos_r;
    eos      = 1'b0;
    done     = 1'b0;
    unique case (st_r)
      ST_START: begin
        if (head.first) begin
          ch       = nsf_pkg::CH_DOLLAR;
          emit_pos = 16'd0;
          st_nxt   = ST_BODY;
        end else if (head.last) begin
          st_nxt = ST_STAR;
        end else begin
          done = 1'b1;
        end
      end
      ST_BODY: begin
        if (head.last) begin
          st_nxt = ST_STAR;
        end else begin
          done   = 1'b1;
          st_nxt = ST_START;
        end
      end
      ST_STAR: begin
        ch     = nsf_pkg::CH_STAR;
        st_nxt = ST_HI;
      end
      ST_HI: begin
        ch     = nsf_pkg::hex_digit(head.cs[7:4]);
        st_nxt = ST_LO;
      end
      ST_LO: begin
        ch     = nsf_pkg::hex_digit(head.cs[3:0]);
        st_nxt = ST_CR;
      end
      ST_CR: begin
        ch     = nsf_pkg::CH_CR;
        st_nxt = ST_LF;
      end
      ST_LF: begin
        ch     = nsf_pkg::CH_LF;
        eos    = 1'b1;
        done   = 1'b1;
        st_nxt = ST_START;
      end
      default: begin
        st_nxt = ST_START;
      end
    endcase
  end

  // Saturating position
  assign pos_inc = (emit_pos == nsf_pkg::POS_MAX) ? emit_pos : emit_pos + 16'd1;

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= 16'hFFFF;
    end else if (cfg_valid) begin
      max_len_r <= cfg_max_length;
    end
  end

  // Sequencer state, position, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_START;
      pos_r       <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        st_r        <= st_nxt;
        pos_r       <= eos ? 16'd0 : pos_inc;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output word
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= ch;
      within_r   <= (emit_pos < max_len_r);
      eos_r      <= eos;
      total_r    <= eos ? pos_inc : 16'd0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_byte            = out_byte_r;
  assign out_within_buffer   = within_r;
  assign out_end_of_sentence = eos_r;
  assign out_total_count     = total_r;

endmodule

/* sv/nmea_sentence_framer_core.sv */
`timescale 1ns / 1ps
// NMEA-style sentence framer.
// Input channel (in_valid / in_stall): one payload byte per word, with
// in_last_byte set on the final byte of a sentence. Output channel
// (out_valid / out_stall): one framed character per word: '$', the payload,
// '*', two upper-case hex checksum digits, CR, LF. Each word tells whether
// its position lies below max_length; the LF word carries the total count.
// Config channel (cfg_valid / cfg_ready, always ready) writes max_length;
// write it only while the block is idle.
// Throughput: one output word per cycle while out_stall is low. A
// mid-sentence byte yields one character; the first byte of a sentence
// adds '$' before it, the last byte adds '*', two hex digits, CR, LF. The
// back-end sequencer, one character per cycle unless stalled, sets that
// rate. A 4-entry queue lets the input run ahead. An accepted byte is queued,
// then its first word ('$' at a sentence start) loads the output register.
// Reset (synchronous, rst_n low) empties the queue and output register,
// clears the checksum and position and sets max_length to 65535.
// When the receiver stalls, the output word holds; the queue fills and then
// in_stall rises.

module nmea_sentence_framer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_payload_byte,
  input  logic        in_last_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_max_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_within_buffer,
  output logic        out_end_of_sentence,
  output logic [15:0] out_total_count
);

  logic                q_full;
  logic                q_not_empty;
  logic                push;
  logic                pop;
  nsf_pkg::nsf_entry_t push_entry;
  nsf_pkg::nsf_entry_t head;

  assign in_stall = q_full;

  nsf_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_payload_byte (in_payload_byte),
    .in_last_byte    (in_last_byte),
    .q_full          (q_full),
    .push            (push),
    .push_entry      (push_entry)
  );

  nsf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (head)
  );

  nsf_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head_valid          (q_not_empty),
    .head                (head),
    .pop                 (pop),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_max_length      (cfg_max_length),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_byte            (out_byte),
    .out_within_buffer   (out_within_buffer),
    .out_end_of_sentence (out_end_of_sentence),
    .out_total_count     (out_total_count)
  );

endmodule

/* bench/tb_nmea_sentence_framer_core.sv */
`timescale 1ns / 1ps

module tb_nmea_sentence_framer_core;

  // One framed character as the block should emit it
  typedef struct {
    logic [7:0]  ch;
    logic        in_buf;
    logic        eos;
    logic [15:0] count;
  } frame_char_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_payload_byte;
  logic        in_last_byte;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_max_length;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        out_within_buffer;
  logic        out_end_of_sentence;
  logic [15:0] out_total_count;

  // Predictor state
  frame_char_t expected_chars[$];
  logic [15:0] buf_cap;
  logic [15:0] char_pos;
  logic [7:0]  run_sum;
  logic        sentence_open;

  int fail_count;
  int src_idle_pct;
  int sink_stall_pct;

  nmea_sentence_framer_core u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_payload_byte     (in_payload_byte),
    .in_last_byte        (in_last_byte),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_max_length      (cfg_max_length),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_byte            (out_byte),
    .out_within_buffer   (out_within_buffer),
    .out_end_of_sentence (out_end_of_sentence),
    .out_total_count     (out_total_count)
  );

  always #10 clk = ~clk;

  // Upper-case hex digit by table lookup
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    string digits;
    digits = "0123456789ABCDEF";
    return digits[v];
  endfunction

  // Queue one emitted character and advance the saturating position
  function automatic void push_char(input logic [7:0] c, input logic eos);
    frame_char_t e;
    e.ch     = c;
    e.in_buf = (char_pos < buf_cap);
    if (char_pos != 16'hFFFF) char_pos = char_pos + 16'd1;
    e.eos    = eos;
    e.count  = eos ? char_pos : 16'd0;
    expected_chars.push_back(e);
  endfunction

  // Characters produced by one accepted payload byte
  function automatic void frame_byte(input logic [7:0] b, input logic last);
    if (!sentence_open) begin
      run_sum       = 8'd0;
      char_pos      = 16'd0;
      sentence_open = 1'b1;
      push_char(nsf_pkg::CH_DOLLAR, 1'b0);
    end
    push_char(b, 1'b0);
    if (b != nsf_pkg::CH_DOLLAR && b != nsf_pkg::CH_STAR) run_sum = run_sum ^ b;
    if (last) begin
      push_char(nsf_pkg::CH_STAR, 1'b0);
      push_char(hex_char(run_sum[7:4]), 1'b0);
      push_char(hex_char(run_sum[3:0]), 1'b0);
      push_char(nsf_pkg::CH_CR, 1'b0);
      push_char(nsf_pkg::CH_LF, 1'b1);
      sentence_open = 1'b0;
      run_sum       = 8'd0;
      char_pos      = 16'd0;
    end
  endfunction

  // Present one payload word, with optional idle cycles ahead of it
  task automatic send_word(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_payload_byte <= b;
    in_last_byte    <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frame_byte(b, last);
  endtask

  // Random payload character: mostly printable, some raw, some delimiters
  function automatic logic [7:0] rand_char();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return nsf_pkg::CH_DOLLAR;
    if (sel == 1) return nsf_pkg::CH_STAR;
    if (sel < 5) return 8'($urandom);
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  task automatic send_sentence(input int len);
    for (int i = 0; i < len; i++) send_word(rand_char(), i == len - 1);
  endtask

  // Stop driving and let every expected word come out
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cap(input logic [15:0] v);
    @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_max_length <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    buf_cap = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver stall, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
  end

  // Compare each accepted output word with the oldest expectation
  always @(posedge clk) begin
    frame_char_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        $error("out_byte: no word expected, got %h", out_byte);
        fail_count++;
      end else begin
        e = expected_chars.pop_front();
        if (out_byte !== e.ch) begin
          $error("out_byte: expected %h, got %h", e.ch, out_byte);
          fail_count++;
        end
        if (out_within_buffer !== e.in_buf) begin
          $error("within_buffer: expected %b, got %b", e.in_buf, out_within_buffer);
          fail_count++;
        end
        if (out_end_of_sentence !== e.eos) begin
          $error("end_of_sentence: expected %b, got %b", e.eos, out_end_of_sentence);
          fail_count++;
        end
        if (out_total_count !== e.count) begin
          $error("total_count: expected %0d, got %0d", e.count, out_total_count);
          fail_count++;
        end
      end
    end
  end

  // Extreme bytes, delimiters, one-byte sentences, reset capacity
  task automatic test_framing();
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b1);
    send_word(nsf_pkg::CH_DOLLAR, 1'b0);
    send_word(nsf_pkg::CH_STAR, 1'b0);
    send_word(8'h5A, 1'b1);
    send_word("G", 1'b0);
    send_word("P", 1'b0);
    send_word("G", 1'b0);
    send_word("S", 1'b0);
    send_word("A", 1'b1);
    send_word(8'hA5, 1'b0);
    send_word(8'h7F, 1'b0);
    send_word(8'h80, 1'b1);
    drain();
  endtask

  // Capacity at zero, small, and changed in the middle of a sentence
  task automatic test_capacity();
    write_cap(16'd0);
    send_sentence(3);
    drain();
    write_cap(16'd1);
    send_sentence(2);
    drain();
    write_cap(16'd65535);
    send_word("A", 1'b0);
    send_word("B", 1'b0);
    send_word("C", 1'b0);
    drain();
    write_cap(16'd2);
    send_word("D", 1'b0);
    send_word("E", 1'b1);
    drain();
  endtask

  // Random well-formed sentences under each idling pattern
  task automatic test_random(input int idle_pct, input int stall_pct,
                             input logic [15:0] cap);
    int words;
    int len;
    words = 0;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    write_cap(cap);
    while (words < 45) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
      send_sentence(len);
      words += len;
    end
    drain();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
  endtask

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_payload_byte = 8'd0;
    in_last_byte    = 1'b0;
    cfg_valid       = 1'b0;
    cfg_max_length  = 16'd0;
    out_stall       = 1'b0;
    fail_count      = 0;
    src_idle_pct    = 0;
    sink_stall_pct  = 0;
    buf_cap         = 16'hFFFF;
    char_pos        = 16'd0;
    run_sum         = 8'd0;
    sentence_open   = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_framing();
    test_capacity();
    test_random(0, 0, 16'hFFFF);
    test_random(73, 0, 16'($urandom_range(0, 16)));
    test_random(0, 73, 16'd0);
    test_random(23, 23, 16'($urandom_range(2, 30)));

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* files.f */
sv/nsf_pkg.sv
sv/nsf_front.sv
sv/nsf_queue.sv
sv/nsf_back.sv
sv/nmea_sentence_framer_core.sv
bench/tb_nmea_sentence_framer_core.sv
